// File: hdl/sfd_pkg.sv
// Shared constants, types and controller/datapath interface for the serial frame detector.
package sfd_pkg;

    localparam int BYTE_W    = 8;
    localparam int BUF_DEPTH = 512;
    localparam int BUF_AW    = $clog2(BUF_DEPTH);
    localparam int IDX_W     = BUF_AW + 1;
    localparam int CAP_DEPTH = 256;
    localparam int CAP_AW    = $clog2(CAP_DEPTH);
    localparam int CFG_AW    = 1;

    localparam logic [BYTE_W-1:0] FLOOR_LEN   = 8'd4;
    localparam logic [BYTE_W-1:0] HEADER_RST  = 8'hC1;
    localparam logic [BYTE_W-1:0] MIN_LEN_RST = 8'd4;

    localparam logic [CFG_AW-1:0] CFG_HEADER  = 1'b0;
    localparam logic [CFG_AW-1:0] CFG_MIN_LEN = 1'b1;

    // receive buffer word: running byte sum up to and including this entry, and the byte
    typedef struct packed {
        logic [BYTE_W-1:0] psum;
        logic [BYTE_W-1:0] data;
    } buf_word_t;

    typedef struct packed {
        logic latch;      // input beat taken
        logic wr_buf;     // store received byte, run length checks
        logic rd_head1;   // buffer read at head + 1
        logic eval;       // checksum verdict cycle
        logic copy;       // issue one copy read
        logic idx_adv;    // advance write index
        logic idx_clr;    // restart write index
        logic load_out;   // load output register
    } sfd_cmd_t;

    typedef struct packed {
        logic len_ok;
        logic chk_ok;
        logic cnt_last;
        logic out_free;
    } sfd_status_t;

endpackage

// File: hdl/sfd_ram.sv
// Generic simple dual-port RAM with registered read.
module sfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/sfd_ctrl.sv
// Sequencing state machine for the frame detector.
module sfd_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    input  logic                 s_tuser,
    output logic                 s_tready,
    input  sfd_pkg::sfd_status_t st,
    output sfd_pkg::sfd_cmd_t    cmd
);
    import sfd_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_RDCAP = 8'b0000_0010,
        ST_WRITE = 8'b0000_0100,
        ST_CK0   = 8'b0000_1000,
        ST_CK1   = 8'b0001_0000,
        ST_CK2   = 8'b0010_0000,
        ST_COPY  = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = s_tuser ? ST_RDCAP : ST_WRITE;
                end
            end
            ST_RDCAP:
            begin
                state_next = ST_DONE;
            end
            ST_WRITE:
            begin
                cmd.wr_buf = 1'b1;
                if (st.len_ok)
                begin
                    state_next = ST_CK0;
                end
                else
                begin
                    cmd.idx_adv = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_CK0:
            begin
                state_next = ST_CK1;
            end
            ST_CK1:
            begin
                cmd.rd_head1 = 1'b1;
                state_next   = ST_CK2;
            end
            ST_CK2:
            begin
                cmd.eval = 1'b1;
                if (st.chk_ok)
                begin
                    state_next = ST_COPY;
                end
                else
                begin
                    cmd.idx_adv = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_COPY:
            begin
                cmd.copy = 1'b1;
                if (st.cnt_last)
                begin
                    cmd.idx_clr = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/sfd_dp.sv
// Datapath: receive buffer with running sums, capture store, checks and output register.
module sfd_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [15:0]                    s_tdata,
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [15:0]                    m_tdata,
    output logic                           m_tuser,
    input  logic                           cfg_we,
    input  logic [sfd_pkg::CFG_AW-1:0]     cfg_addr,
    input  logic [sfd_pkg::BYTE_W-1:0]     cfg_data,
    input  sfd_pkg::sfd_cmd_t              cmd,
    output sfd_pkg::sfd_status_t           st
);
    import sfd_pkg::*;

    logic [BYTE_W-1:0] hdr_reg, min_reg;
    logic [BUF_AW-1:0] wr_idx_reg;
    logic              act_reg;
    logic [BYTE_W-1:0] rx_reg, ridx_reg;
    logic [BUF_AW-1:0] head_reg;
    logic [BYTE_W-1:0] hb_reg;
    logic [BYTE_W-1:0] psum_reg, psum_prev_reg, last_byte_reg;
    logic [BYTE_W-1:0] chk_byte_reg, chk_psum_reg;
    logic              ok_reg;
    logic [CAP_AW-1:0] cnt_reg;
    logic              cap_we_reg;
    logic [CAP_AW-1:0] cap_wa_reg;
    logic              m_tvalid_reg;
    logic [15:0]       m_tdata_reg;
    logic              m_tuser_reg;

    buf_word_t         buf_wdata, buf_rdata;
    logic [BUF_AW-1:0] buf_raddr;
    logic [BYTE_W-1:0] cap_rdata;
    logic [BYTE_W-1:0] min_eff;
    logic [IDX_W-1:0]  idx_ext, len_ext;
    logic [BUF_AW-1:0] head_calc;
    logic [BYTE_W-1:0] sum_calc;

    // buffer write at the current index; entry holds the running sum through it
    assign buf_wdata.data = rx_reg;
    assign buf_wdata.psum = psum_reg + rx_reg;

    always_comb
    begin
        priority if (cmd.rd_head1)
        begin
            buf_raddr = head_reg + BUF_AW'(1);
        end
        else if (cmd.copy)
        begin
            buf_raddr = head_reg + BUF_AW'(cnt_reg);
        end
        else
        begin
            buf_raddr = head_reg;
        end
    end

    sfd_ram #(
        .WIDTH ($bits(buf_word_t)),
        .DEPTH (BUF_DEPTH)
    ) u_buf_ram (
        .clk   (clk),
        .we    (cmd.wr_buf),
        .waddr (wr_idx_reg),
        .wdata (buf_wdata),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    sfd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (CAP_DEPTH)
    ) u_cap_ram (
        .clk   (clk),
        .we    (cap_we_reg),
        .waddr (cap_wa_reg),
        .wdata (buf_rdata.data),
        .raddr (ridx_reg),
        .rdata (cap_rdata)
    );

    // length byte checks
    assign min_eff   = (min_reg < FLOOR_LEN) ? FLOOR_LEN : min_reg;
    assign idx_ext   = IDX_W'(wr_idx_reg) + IDX_W'(1);
    assign len_ext   = IDX_W'(rx_reg);
    assign head_calc = BUF_AW'(idx_ext - len_ext);

    // body sum is the difference of running sums at i-2 and head+1
    assign sum_calc = hb_reg + rx_reg + chk_psum_reg - buf_rdata.psum;

    assign st.len_ok   = (rx_reg >= min_eff) && (len_ext <= idx_ext);
    assign st.chk_ok   = (hb_reg == hdr_reg) && (buf_rdata.data == chk_byte_reg)
                         && (sum_calc == chk_byte_reg);
    assign st.cnt_last = (cnt_reg == (rx_reg - 8'd1));
    assign st.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg      <= HEADER_RST;
            min_reg      <= MIN_LEN_RST;
            wr_idx_reg   <= '0;
            psum_reg     <= '0;
            ok_reg       <= 1'b0;
            cap_we_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_HEADER:  hdr_reg <= cfg_data;
                    CFG_MIN_LEN: min_reg <= cfg_data;
                endcase
            end
            priority if (cmd.idx_clr)
            begin
                wr_idx_reg <= '0;
            end
            else if (cmd.idx_adv)
            begin
                wr_idx_reg <= (wr_idx_reg == BUF_AW'(BUF_DEPTH - 1)) ? '0
                              : wr_idx_reg + BUF_AW'(1);
            end
            if (cmd.wr_buf)
            begin
                psum_reg <= buf_wdata.psum;
            end
            if (cmd.latch)
            begin
                ok_reg <= 1'b0;
            end
            else if (cmd.eval)
            begin
                ok_reg <= st.chk_ok;
            end
            cap_we_reg <= cmd.copy;
            if (cmd.load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            act_reg  <= s_tuser;
            rx_reg   <= s_tdata[7:0];
            ridx_reg <= s_tdata[15:8];
        end
        if (cmd.wr_buf)
        begin
            head_reg      <= head_calc;
            chk_byte_reg  <= last_byte_reg;
            chk_psum_reg  <= psum_prev_reg;
            last_byte_reg <= rx_reg;
            psum_prev_reg <= psum_reg;
        end
        if (cmd.rd_head1)
        begin
            hb_reg <= buf_rdata.data;
        end
        if (cmd.eval)
        begin
            cnt_reg <= '0;
        end
        else if (cmd.copy)
        begin
            cnt_reg <= cnt_reg + CAP_AW'(1);
        end
        cap_wa_reg <= cnt_reg;
        if (cmd.load_out)
        begin
            m_tuser_reg <= ok_reg;
            m_tdata_reg <= {act_reg ? cap_rdata : 8'd0, ok_reg ? rx_reg : 8'd0};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// File: hdl/serial_frame_detector_checksum.sv
// A read beat reads the capture store, then loads its result. A receive beat is stored and
// length checked, then header and checksum checked, and an accepted frame is then copied.
// Accepted frames are copied into the capture store one byte per cycle.
// One beat is taken at a time; a result may wait while the next beat enters.
// Reset clears control, write index, running sum, configuration and output valid; no RAM clearing pass.
module serial_frame_detector_checksum (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [15:0]                s_tdata,   // rx_byte[7:0], read_index[15:8]
    input  logic                       s_tuser,   // action
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,   // frame_length[7:0], read_data[15:8]
    output logic                       m_tuser,   // frame_ok
    input  logic                       cfg_we,
    input  logic [sfd_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [sfd_pkg::BYTE_W-1:0] cfg_data
);
    import sfd_pkg::*;

    sfd_cmd_t    cmd;
    sfd_status_t st;

    sfd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    sfd_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .st       (st)
    );

endmodule

// File: hdl/sfd_checker.sv
// Port-level assertions for the frame detector, bound to the top level.
module sfd_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser,
    input logic        cfg_we,
    input logic [0:0]  cfg_addr,
    input logic [7:0]  cfg_data
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // a frame result carries a real length and no read data
    a_frame_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[15:8] == 8'd0) && (m_tdata[7:0] >= 8'd4))
        else $error("frame result fields inconsistent");

    // no frame, no length
    a_no_frame_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
        else $error("length reported without a frame");

    // one beat at a time: busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous beat in progress");

endmodule

bind serial_frame_detector_checksum sfd_checker u_sfd_checker (.*);
